[rtl/jfss_pkg.sv]
`default_nettype none

package jfss_pkg;

    // Byte values that carry meaning in the stream
    localparam logic [7:0] BYTE_FILL = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_SOF0 = 8'hC0;
    localparam logic [7:0] BYTE_SOF1 = 8'hC1;
    localparam logic [7:0] BYTE_SOF2 = 8'hC2;

    typedef logic [1:0] t_status;

    localparam t_status ST_FOUND  = 2'd0;
    localparam t_status ST_NO_SOI = 2'd1;
    localparam t_status ST_NO_SOF = 2'd2;
    localparam t_status ST_ZERO   = 2'd3;

endpackage

`default_nettype wire

[rtl/jpeg_frame_size_scanner.sv]
`default_nettype none

// Channel  | Signals                                      | Direction
// ---------+----------------------------------------------+----------
// byte in  | i_valid, o_stall, i_data_byte, i_last_byte   | in
// status   | o_valid, i_stall, o_status, o_image_width,   | out
//          | o_image_height                               |
//
// Cycles: one byte is taken every cycle unless o_stall is high; its state
// update is done in the cycle it is accepted, and a status appears on the
// output register in the cycle after the byte that decided it.
// Reset: synchronous, active low; clears the parse state and the output valid.
// Stalls: the output register holds a status while i_stall is high; the input
// side stalls only when that register is full and held.
module jpeg_frame_size_scanner (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output jfss_pkg::t_status  o_status,
    output      logic [15:0]   o_image_width,
    output      logic [15:0]   o_image_height
);

    // Parse phases
    localparam logic [3:0] PH_SOI_FIRST  = 4'd0;
    localparam logic [3:0] PH_SOI_SECOND = 4'd1;
    localparam logic [3:0] PH_HUNT       = 4'd2;
    localparam logic [3:0] PH_FILL       = 4'd3;
    localparam logic [3:0] PH_LEN_HIGH   = 4'd4;
    localparam logic [3:0] PH_LEN_LOW    = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_PRECISION  = 4'd7;
    localparam logic [3:0] PH_H_HIGH     = 4'd8;
    localparam logic [3:0] PH_H_LOW      = 4'd9;
    localparam logic [3:0] PH_W_HIGH     = 4'd10;
    localparam logic [3:0] PH_W_LOW      = 4'd11;

    // Parse state
    logic [3:0]  r_phase,       n_phase;
    logic        r_frame_seen,  n_frame_seen;
    logic [7:0]  r_len_high,    n_len_high;
    logic [15:0] r_skip,        n_skip;
    logic [15:0] r_height,      n_height;
    logic [7:0]  r_width_high,  n_width_high;
    logic        r_reported,    n_reported;

    // Output register
    logic              r_out_valid, n_out_valid;
    jfss_pkg::t_status r_status,    n_status;
    logic [15:0]       r_width,     n_width;
    logic [15:0]       r_out_height, n_out_height;

    logic        in_accept;
    logic        out_taken;
    logic        emit;
    logic [15:0] len_word;
    logic [15:0] width_word;

    // Stall input only while a status is waiting and downstream holds it
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign out_taken = r_out_valid && !i_stall;

    assign len_word   = {r_len_high, i_data_byte};
    assign width_word = {r_width_high, i_data_byte};

    always_comb begin
        n_phase      = r_phase;
        n_frame_seen = r_frame_seen;
        n_len_high   = r_len_high;
        n_skip       = r_skip;
        n_height     = r_height;
        n_width_high = r_width_high;
        n_reported   = r_reported;
        emit         = 1'b0;
        n_status     = r_status;
        n_width      = r_width;
        n_out_height = r_out_height;

        if (in_accept) begin
            if (!r_reported) begin
                case (r_phase)
                    PH_SOI_FIRST: begin
                        if (i_data_byte == jfss_pkg::BYTE_FILL) begin
                            n_phase = PH_SOI_SECOND;
                        end else begin
                            emit         = 1'b1;
                            n_status     = jfss_pkg::ST_NO_SOI;
                            n_width      = '0;
                            n_out_height = '0;
                        end
                    end
                    PH_SOI_SECOND: begin
                        if (i_data_byte == jfss_pkg::BYTE_SOI) begin
                            n_phase = PH_HUNT;
                        end else begin
                            emit         = 1'b1;
                            n_status     = jfss_pkg::ST_NO_SOI;
                            n_width      = '0;
                            n_out_height = '0;
                        end
                    end
                    PH_HUNT: begin
                        if (i_data_byte == jfss_pkg::BYTE_FILL) begin
                            n_phase = PH_FILL;
                        end
                    end
                    PH_FILL: begin
                        // Skip fill bytes; the first other byte is the marker
                        if (i_data_byte != jfss_pkg::BYTE_FILL) begin
                            n_frame_seen = i_data_byte inside {jfss_pkg::BYTE_SOF0,
                                                               jfss_pkg::BYTE_SOF1,
                                                               jfss_pkg::BYTE_SOF2};
                            n_phase = PH_LEN_HIGH;
                        end
                    end
                    PH_LEN_HIGH: begin
                        n_len_high = i_data_byte;
                        n_phase    = PH_LEN_LOW;
                    end
                    PH_LEN_LOW: begin
                        if (r_frame_seen) begin
                            n_phase = PH_PRECISION;
                        end else if (len_word > 16'd2) begin
                            n_skip  = len_word - 16'd2;
                            n_phase = PH_SKIP;
                        end else begin
                            n_skip  = '0;
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_SKIP: begin
                        if (r_skip != '0) begin
                            n_skip = r_skip - 16'd1;
                        end
                        if (r_skip <= 16'd1) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_PRECISION: begin
                        n_phase = PH_H_HIGH;
                    end
                    PH_H_HIGH: begin
                        n_height = {i_data_byte, 8'd0};
                        n_phase  = PH_H_LOW;
                    end
                    PH_H_LOW: begin
                        n_height = {r_height[15:8], r_height[7:0] | i_data_byte};
                        n_phase  = PH_W_HIGH;
                    end
                    PH_W_HIGH: begin
                        n_width_high = i_data_byte;
                        n_phase      = PH_W_LOW;
                    end
                    PH_W_LOW: begin
                        emit = 1'b1;
                        if (width_word != '0 && r_height != '0) begin
                            n_status     = jfss_pkg::ST_FOUND;
                            n_width      = width_word;
                            n_out_height = r_height;
                        end else begin
                            n_status     = jfss_pkg::ST_ZERO;
                            n_width      = '0;
                            n_out_height = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
                if (emit) begin
                    n_reported = 1'b1;
                end
            end

            // Last byte: report the fallback if nothing went out, then rearm
            if (i_last_byte) begin
                if (!n_reported) begin
                    emit         = 1'b1;
                    n_status     = (n_phase == PH_SOI_SECOND) ? jfss_pkg::ST_NO_SOI
                                                              : jfss_pkg::ST_NO_SOF;
                    n_width      = '0;
                    n_out_height = '0;
                end
                n_phase      = PH_SOI_FIRST;
                n_frame_seen = 1'b0;
                n_len_high   = '0;
                n_skip       = '0;
                n_height     = '0;
                n_width_high = '0;
                n_reported   = 1'b0;
            end
        end

        // Drop the held status once taken; load a new one when produced
        n_out_valid = (r_out_valid && !out_taken) || emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SOI_FIRST;
            r_frame_seen <= 1'b0;
            r_len_high   <= '0;
            r_skip       <= '0;
            r_height     <= '0;
            r_width_high <= '0;
            r_reported   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_frame_seen <= n_frame_seen;
            r_len_high   <= n_len_high;
            r_skip       <= n_skip;
            r_height     <= n_height;
            r_width_high <= n_width_high;
            r_reported   <= n_reported;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload: load only with a new status, hold otherwise
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status     <= n_status;
            r_width      <= n_width;
            r_out_height <= n_out_height;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_image_width  = r_width;
    assign o_image_height = r_out_height;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // Cycles with no item moving on either side before the run is declared hung.
    // The longest legal quiet stretch is the forced receiver hold plus one gap.
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_BYTES  = 1000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        jfss_pkg::t_status status;
        logic [15:0]       width;
        logic [15:0]       height;
    } t_size_report;

    // One row of the directed table: the byte, its end-of-file flag, and a
    // typed-in status where the outcome is plain from the byte sequence.
    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        t_size_report rep;
    } t_byte_row;

    typedef enum logic [3:0] {
        SCAN_SOI_FIRST,
        SCAN_SOI_SECOND,
        SCAN_HUNT,
        SCAN_FILL,
        SCAN_LEN_HIGH,
        SCAN_LEN_LOW,
        SCAN_SKIP,
        SCAN_PRECISION,
        SCAN_H_HIGH,
        SCAN_H_LOW,
        SCAN_W_HIGH,
        SCAN_W_LOW
    } t_scan_phase;

    localparam t_size_report NO_REPORT = '0;

    // Directed files, back to back:
    //   a lone bad first byte, a file of just FF, a file ending right after
    //   the start pair, a bad second start byte followed by an ignored byte,
    //   and a file with a too-short segment length, fill bytes, and a frame
    //   header of zero height that completes on the final byte.
    localparam t_byte_row DIRECTED_ROWS [0:22] = '{
        '{8'h00, 1'b1, 1'b1, '{jfss_pkg::ST_NO_SOI, 16'd0, 16'd0}},
        '{8'hFF, 1'b1, 1'b1, '{jfss_pkg::ST_NO_SOI, 16'd0, 16'd0}},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hD8, 1'b1, 1'b1, '{jfss_pkg::ST_NO_SOF, 16'd0, 16'd0}},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b1, '{jfss_pkg::ST_NO_SOI, 16'd0, 16'd0}},
        '{8'h55, 1'b1, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hD8, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hE0, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h01, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hC1, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h08, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b1, 1'b1, '{jfss_pkg::ST_ZERO, 16'd0, 16'd0}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_last_byte = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    jfss_pkg::t_status o_status;
    logic [15:0]       o_image_width;
    logic [15:0]       o_image_height;

    jpeg_frame_size_scanner i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the parser state, advanced once per accepted item.
    t_scan_phase  scan_phase;
    logic         scan_frame_marker;
    logic [7:0]   scan_len_high;
    logic [15:0]  scan_skip_left;
    logic [15:0]  scan_height;
    logic [7:0]   scan_width_high;
    logic         scan_reported;

    t_size_report pending_sizes [$];
    logic [7:0]   file_buf [$];

    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  files_sent   = 0;
    int  reports_seen = 0;
    int  frames_found = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_request = 1'b0;
    bit  calm         = 1'b0;

    function automatic void clear_scanner();
        scan_phase        = SCAN_SOI_FIRST;
        scan_frame_marker = 1'b0;
        scan_len_high     = 8'h00;
        scan_skip_left    = 16'h0000;
        scan_height       = 16'h0000;
        scan_width_high   = 8'h00;
        scan_reported     = 1'b0;
    endfunction

    // Advance the parser by one byte; report a status when the byte decides one.
    function automatic void scan_byte(input logic [7:0] b, input logic last,
                                      output logic got, output t_size_report rep);
        logic [15:0] seg_len;
        logic [15:0] width;
        got = 1'b0;
        rep = NO_REPORT;
        if (!scan_reported) begin
            case (scan_phase)
                SCAN_SOI_FIRST: begin
                    if (b == jfss_pkg::BYTE_FILL) scan_phase = SCAN_SOI_SECOND;
                    else begin
                        got = 1'b1;
                        rep.status = jfss_pkg::ST_NO_SOI;
                    end
                end
                SCAN_SOI_SECOND: begin
                    if (b == jfss_pkg::BYTE_SOI) scan_phase = SCAN_HUNT;
                    else begin
                        got = 1'b1;
                        rep.status = jfss_pkg::ST_NO_SOI;
                    end
                end
                SCAN_HUNT: begin
                    if (b == jfss_pkg::BYTE_FILL) scan_phase = SCAN_FILL;
                end
                SCAN_FILL: begin
                    if (b != jfss_pkg::BYTE_FILL) begin
                        scan_frame_marker = (b == jfss_pkg::BYTE_SOF0 ||
                                             b == jfss_pkg::BYTE_SOF1 ||
                                             b == jfss_pkg::BYTE_SOF2);
                        scan_phase = SCAN_LEN_HIGH;
                    end
                end
                SCAN_LEN_HIGH: begin
                    scan_len_high = b;
                    scan_phase = SCAN_LEN_LOW;
                end
                SCAN_LEN_LOW: begin
                    seg_len = {scan_len_high, b};
                    if (scan_frame_marker) scan_phase = SCAN_PRECISION;
                    else if (seg_len > 16'd2) begin
                        scan_skip_left = seg_len - 16'd2;
                        scan_phase = SCAN_SKIP;
                    end else begin
                        scan_skip_left = 16'd0;
                        scan_phase = SCAN_HUNT;
                    end
                end
                SCAN_SKIP: begin
                    if (scan_skip_left != 16'd0) scan_skip_left = scan_skip_left - 16'd1;
                    if (scan_skip_left == 16'd0) scan_phase = SCAN_HUNT;
                end
                SCAN_PRECISION: scan_phase = SCAN_H_HIGH;
                SCAN_H_HIGH: begin
                    scan_height = {b, 8'h00};
                    scan_phase = SCAN_H_LOW;
                end
                SCAN_H_LOW: begin
                    scan_height[7:0] = b;
                    scan_phase = SCAN_W_HIGH;
                end
                SCAN_W_HIGH: begin
                    scan_width_high = b;
                    scan_phase = SCAN_W_LOW;
                end
                SCAN_W_LOW: begin
                    width = {scan_width_high, b};
                    got = 1'b1;
                    if (width != 16'd0 && scan_height != 16'd0)
                        rep = '{jfss_pkg::ST_FOUND, width, scan_height};
                    else
                        rep.status = jfss_pkg::ST_ZERO;
                end
                default: scan_phase = SCAN_HUNT;
            endcase
            if (got) scan_reported = 1'b1;
        end
        // Final byte: fall back to a failure status if nothing was reported, then rearm.
        if (last) begin
            if (!scan_reported) begin
                got = 1'b1;
                rep = NO_REPORT;
                rep.status = (scan_phase == SCAN_SOI_SECOND) ? jfss_pkg::ST_NO_SOI
                                                             : jfss_pkg::ST_NO_SOF;
            end
            clear_scanner();
        end
    endfunction

    // Offer one item after a random gap, hold it until accepted, then predict.
    // Called right after a rising edge, so each signal gets one update per step.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_size_report typed_rep);
        int           gap;
        logic         got;
        t_size_report rep;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scan_byte(b, last, got, rep);
        if (typed) begin
            got = 1'b1;
            rep = typed_rep;
        end
        if (got) pending_sizes.push_back(rep);
        bytes_sent++;
    endtask

    function automatic logic [15:0] pick_dimension();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one file into file_buf. Most files are well formed: start pair,
    // a few non-frame segments, a frame header, some trailing bytes. Some are
    // cut short at a random point, and a few are plain noise.
    task automatic build_file();
        int          kind;
        logic [7:0]  marker;
        logic [15:0] seg_len;
        logic [15:0] dim;
        int          keep;
        file_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            if ($urandom_range(0, 1)) file_buf.push_back(jfss_pkg::BYTE_FILL);
            if ($urandom_range(0, 1)) file_buf.push_back(jfss_pkg::BYTE_SOI);
            repeat ($urandom_range(1, 10)) file_buf.push_back(8'($urandom));
        end else begin
            file_buf.push_back(jfss_pkg::BYTE_FILL);
            file_buf.push_back(jfss_pkg::BYTE_SOI);
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(0, 1)) file_buf.push_back(8'($urandom_range(0, 254)));
                file_buf.push_back(jfss_pkg::BYTE_FILL);
                repeat ($urandom_range(0, 2)) file_buf.push_back(jfss_pkg::BYTE_FILL);
                do marker = 8'($urandom);
                while (marker == jfss_pkg::BYTE_FILL || marker == jfss_pkg::BYTE_SOF0 ||
                       marker == jfss_pkg::BYTE_SOF1 || marker == jfss_pkg::BYTE_SOF2);
                file_buf.push_back(marker);
                seg_len = 16'($urandom_range(0, 24));
                file_buf.push_back(seg_len[15:8]);
                file_buf.push_back(seg_len[7:0]);
                if (seg_len > 16'd2)
                    repeat (int'(seg_len) - 2) file_buf.push_back(8'($urandom));
            end
            file_buf.push_back(jfss_pkg::BYTE_FILL);
            repeat ($urandom_range(0, 2)) file_buf.push_back(jfss_pkg::BYTE_FILL);
            case ($urandom_range(0, 2))
                0: file_buf.push_back(jfss_pkg::BYTE_SOF0);
                1: file_buf.push_back(jfss_pkg::BYTE_SOF1);
                default: file_buf.push_back(jfss_pkg::BYTE_SOF2);
            endcase
            // The frame length is never used, so any value goes.
            repeat (3) file_buf.push_back(8'($urandom));
            dim = pick_dimension();
            file_buf.push_back(dim[15:8]);
            file_buf.push_back(dim[7:0]);
            dim = pick_dimension();
            file_buf.push_back(dim[15:8]);
            file_buf.push_back(dim[7:0]);
            repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
            if (kind == 2) begin
                keep = $urandom_range(1, file_buf.size());
                while (file_buf.size() > keep) void'(file_buf.pop_back());
            end
        end
    endtask

    // Receiver: draw a hold for each result and count it down while a result waits.
    // A one-off long hold lets the output register fill and back up the input.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) hold_left = calm ? 0 : $urandom_range(0, 12);
        else if (o_valid && hold_left > 0) hold_left--;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        i_stall <= (hold_left != 0);
    end

    // Compare each accepted status with the oldest expected one.
    always @(posedge i_clk) begin
        t_size_report exp_rep;
        if (i_rst_n && o_valid && !i_stall) begin
            reports_seen++;
            if (pending_sizes.size() == 0) begin
                $display("%0t: unexpected status, expected none, got status %0d %0dx%0d",
                         $time, o_status, o_image_width, o_image_height);
                mismatches++;
            end else begin
                exp_rep = pending_sizes.pop_front();
                if (exp_rep.status == jfss_pkg::ST_FOUND) frames_found++;
                if (o_status !== exp_rep.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp_rep.status, o_status);
                    mismatches++;
                end
                if (o_image_width !== exp_rep.width) begin
                    $display("%0t: width mismatch, expected %0d, got %0d",
                             $time, exp_rep.width, o_image_width);
                    mismatches++;
                end
                if (o_image_height !== exp_rep.height) begin
                    $display("%0t: height mismatch, expected %0d, got %0d",
                             $time, exp_rep.height, o_image_height);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d statuses still expected",
                     $time, QUIET_LIMIT, pending_sizes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int random_start;
        clear_scanner();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rep);
        files_sent = 5;

        // Random files; the long hold is requested as this part starts and meets the next result that waits.
        hold_request = 1'b1;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            build_file();
            calm = ($urandom_range(0, 3) == 0);
            foreach (file_buf[i])
                send_byte(file_buf[i], i == file_buf.size() - 1, 1'b0, NO_REPORT);
            files_sent++;
        end
        i_valid <= 1'b0;

        while (pending_sizes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d files in %0d bytes with random gaps and stalls.",
                 files_sent, bytes_sent);
        $display("Checked %0d statuses, %0d of them frame sizes found; %0d mismatches.",
                 reports_seen, frames_found, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/jfss_pkg.sv
rtl/jpeg_frame_size_scanner.sv
dv/testbench.sv
